>>> rtl/tfn_pkg.sv
// shared types and constants of the triangle facet normal block
`timescale 1ns / 1ps

package tfn_pkg;

   localparam int COORD_W    = 16;
   localparam int SLOT_W     = 10;
   localparam int NORM_W     = 16;
   localparam int FACET_W    = 20;
   localparam int ADDR_MAX_W = 16;
   localparam int NORM_ONE   = 16384;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TRI  = 1'b1;

   typedef struct packed {
      logic                      command;
      logic [SLOT_W-1:0]         vertex_slot;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [SLOT_W-1:0]         corner_a;
      logic [SLOT_W-1:0]         corner_b;
      logic [SLOT_W-1:0]         corner_c;
   } req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic                     degenerate;
      logic [FACET_W-1:0]       facet_number;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vertex_type;

   // one decoded item between front and back
   typedef struct packed {
      logic                  command;
      logic [ADDR_MAX_W-1:0] addr_0;
      logic [ADDR_MAX_W-1:0] addr_1;
      logic [ADDR_MAX_W-1:0] addr_2;
      vertex_type            vtx;
   } job_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_MAX_W-1:0] wr_addr;
      vertex_type            wr_data;
      logic [ADDR_MAX_W-1:0] rd_addr;
   } mem_req_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_READ_B,
      BK_READ_C,
      BK_TAKE_C,
      BK_MULT,
      BK_CROSS,
      BK_SCALE,
      BK_SQUARE,
      BK_SUM,
      BK_ROOT,
      BK_PREP,
      BK_DIVIDE,
      BK_DONE
   } back_state_type;

endpackage

>>> rtl/triangle_facet_normal_top.sv
// top level of the triangle facet normal block
`timescale 1ns / 1ps

//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_payload (tfn_pkg::req_type)
//  rsp      out        rsp_valid / rsp_ready  rsp_payload (tfn_pkg::rsp_type)
//
//  a load item is one store write, taken while the back end is idle
//  a triangle item takes 3 store reads, cross product, digit-by-digit square root and
//  the three-lane divider; a degenerate one goes from the cross product to the result
//  a two-item queue lets the front keep taking items while the back works and while
//  a result waits in the output register; reset clears control and the triangle
//  counter, the vertex store holds whatever it held until written

module triangle_facet_normal_top #(
   parameter int VERTEX_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tfn_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tfn_pkg::rsp_type rsp_payload
);

   import tfn_pkg::*;

   localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

   // front to queue
   logic        front_valid, front_ready;
   job_type     front_job;
   // queue to back
   logic        back_valid, back_ready;
   job_type     back_job;
   // back to vertex store
   mem_req_type mem_req;
   vertex_type  mem_rd_data;

   // decode and address wrap
   tfn_front #(
      .VERTEX_DEPTH(VERTEX_DEPTH)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .job_valid  (front_valid),
      .job_ready  (front_ready),
      .job        (front_job)
   );

   // decouples front from the long triangle computation
   tfn_queue #(
      .WIDTH($bits(job_type))
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (front_valid),
      .in_ready (front_ready),
      .in_data  (front_job),
      .out_valid(back_valid),
      .out_ready(back_ready),
      .out_data (back_job)
   );

   // loads write here in order with triangle reads, so no hazard tracking needed
   tfn_ram #(
      .WIDTH($bits(vertex_type)),
      .DEPTH(VERTEX_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_req.wr_en),
      .wr_addr(mem_req.wr_addr[AW-1:0]),
      .wr_data(mem_req.wr_data),
      .rd_addr(mem_req.rd_addr[AW-1:0]),
      .rd_data(mem_rd_data)
   );

   // cross product, normalization and output register
   tfn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (back_valid),
      .job_ready  (back_ready),
      .job        (back_job),
      .mem_req    (mem_req),
      .mem_rd_data(mem_rd_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

>>> rtl/tfn_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tfn_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tfn_front.sv
// front end: decodes items and wraps store addresses into the store depth
`timescale 1ns / 1ps

module tfn_front #(
   parameter int VERTEX_DEPTH = 1024
) (
   input  logic             req_valid,
   output logic             req_ready,
   input  tfn_pkg::req_type req_payload,
   output logic             job_valid,
   input  logic             job_ready,
   output tfn_pkg::job_type job
);

   import tfn_pkg::*;

   localparam int AW         = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int MIN_DEPTH  = 16;
   localparam int WRAP_STEPS = SLOT_W - $clog2(MIN_DEPTH) + 1;
   localparam int WRAP_W     = 24;

   // binary compare-subtract reduction, slot mod depth
   function automatic logic [AW-1:0] wrap_slot(input logic [SLOT_W-1:0] slot);
      logic [WRAP_W-1:0] r;
      logic [WRAP_W-1:0] step;
      r = WRAP_W'(slot);
      for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
         step = WRAP_W'(VERTEX_DEPTH) << k;
         if (r >= step) begin
            r = r - step;
         end
      end
      return r[AW-1:0];
   endfunction

   always_comb begin
      job.command = req_payload.command;
      if (req_payload.command == CMD_LOAD) begin
         job.addr_0 = ADDR_MAX_W'(wrap_slot(req_payload.vertex_slot));
      end else begin
         job.addr_0 = ADDR_MAX_W'(wrap_slot(req_payload.corner_a));
      end
      job.addr_1 = ADDR_MAX_W'(wrap_slot(req_payload.corner_b));
      job.addr_2 = ADDR_MAX_W'(wrap_slot(req_payload.corner_c));
      job.vtx.x  = req_payload.coord_x;
      job.vtx.y  = req_payload.coord_y;
      job.vtx.z  = req_payload.coord_z;
   end

   assign job_valid = req_valid;
   assign req_ready = job_ready;

endmodule

>>> rtl/tfn_queue.sv
// two entry item queue between front and back
`timescale 1ns / 1ps

module tfn_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> rtl/tfn_back.sv
// back end: store writes, cross product, square root and normalizing divide
`timescale 1ns / 1ps

module tfn_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  tfn_pkg::job_type     job,
   output tfn_pkg::mem_req_type mem_req,
   input  tfn_pkg::vertex_type  mem_rd_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tfn_pkg::rsp_type     rsp_payload
);

   import tfn_pkg::*;

   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int MAG_W      = 30;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int SREM_W     = ROOT_W + 2;
   localparam int FRAC_BITS  = 14;
   localparam int DIV_STEPS  = FRAC_BITS + 1;
   localparam int NUM_W      = MAG_W + FRAC_BITS + 1;
   localparam int SHIFT_W    = $clog2(CROSS_W - MAG_W + 1);
   localparam int ROOT_STEPS = ROOT_W;
   localparam int ITER_W     = $clog2(ROOT_STEPS);

   back_state_type state_ff, state_in;

   logic [ADDR_MAX_W-1:0]     addr_b_ff, addr_c_ff;
   logic signed [COORD_W-1:0] va_ff [3];
   logic signed [COORD_W-1:0] vb_ff [3];
   logic signed [COORD_W-1:0] rd_c [3];
   logic signed [DIFF_W-1:0]  u_ff [3];
   logic signed [DIFF_W-1:0]  v_ff [3];
   logic signed [PROD_W-1:0]  p_ff [6];
   logic signed [CROSS_W-1:0] c_ff [3];
   logic signed [CROSS_W-1:0] c_in [3];
   logic [CROSS_W-1:0]        abs_c [3];
   logic [CROSS_W-1:0]        max_mag;
   logic [SHIFT_W-1:0]        shift_amt;
   logic [MAG_W-1:0]          mag_ff [3];
   logic                      neg_ff [3];
   logic                      degen_ff, degen_in;
   logic [SQ_W-1:0]           sq_ff [3];
   logic [SUM_W-1:0]          sum_ff;
   logic [ROOT_W-1:0]         root_ff, root_in, len_in, len_ff;
   logic [SREM_W-1:0]         srem_ff, srem_in;
   logic [SREM_W+1:0]         rem_cat, trial;
   logic [ITER_W-1:0]         iter_ff;
   logic [NUM_W-1:0]          num [3];
   logic [ROOT_W-1:0]         drem_ff [3];
   logic [ROOT_W-1:0]         drem_in [3];
   logic [ROOT_W:0]           dshift [3];
   logic [DIV_STEPS-1:0]      dnum_ff [3];
   logic [DIV_STEPS-1:0]      quo_ff [3];
   logic                      qbit [3];
   logic [DIV_STEPS-1:0]      qclip [3];
   logic signed [NORM_W-1:0]  norm [3];
   logic [FACET_W-1:0]        facet_ff;
   rsp_type                   rsp_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_load;

   assign rsp_load = (state_ff == BK_DONE) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (job_valid && job.command == CMD_TRI) state_in = BK_READ_B;
         BK_READ_B: state_in = BK_READ_C;
         BK_READ_C: state_in = BK_TAKE_C;
         BK_TAKE_C: state_in = BK_MULT;
         BK_MULT:   state_in = BK_CROSS;
         BK_CROSS:  state_in = degen_in ? BK_DONE : BK_SCALE;
         BK_SCALE:  state_in = BK_SQUARE;
         BK_SQUARE: state_in = BK_SUM;
         BK_SUM:    state_in = BK_ROOT;
         BK_ROOT:   if (iter_ff == '0) state_in = BK_PREP;
         BK_PREP:   state_in = BK_DIVIDE;
         BK_DIVIDE: if (iter_ff == '0) state_in = BK_DONE;
         BK_DONE:   if (rsp_load) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      job_ready       = (state_ff == BK_IDLE);
      mem_req.wr_en   = (state_ff == BK_IDLE) && job_valid && (job.command == CMD_LOAD);
      mem_req.wr_addr = job.addr_0;
      mem_req.wr_data = job.vtx;
      case (state_ff)
         BK_READ_B: mem_req.rd_addr = addr_b_ff;
         BK_READ_C: mem_req.rd_addr = addr_c_ff;
         default:   mem_req.rd_addr = job.addr_0;
      endcase
   end

   // datapath arithmetic
   always_comb begin
      rd_c[0] = mem_rd_data.x;
      rd_c[1] = mem_rd_data.y;
      rd_c[2] = mem_rd_data.z;

      c_in[0] = CROSS_W'(p_ff[0]) - CROSS_W'(p_ff[1]);
      c_in[1] = CROSS_W'(p_ff[2]) - CROSS_W'(p_ff[3]);
      c_in[2] = CROSS_W'(p_ff[4]) - CROSS_W'(p_ff[5]);
      degen_in = (c_in[0] == '0) && (c_in[1] == '0) && (c_in[2] == '0);

      max_mag = '0;
      for (int k = 0; k < 3; k++) begin
         abs_c[k] = c_ff[k][CROSS_W-1] ? CROSS_W'(-c_ff[k]) : CROSS_W'(c_ff[k]);
         if (abs_c[k] > max_mag) max_mag = abs_c[k];
      end
      shift_amt = '0;
      for (int j = MAG_W; j < CROSS_W; j++) begin
         if (max_mag[j]) shift_amt = SHIFT_W'(j - MAG_W + 1);
      end

      // one root digit a cycle
      rem_cat = {srem_ff, sum_ff[SUM_W-1 -: 2]};
      trial   = (SREM_W+2)'({root_ff, 2'b01});
      if (rem_cat >= trial) begin
         srem_in = SREM_W'(rem_cat - trial);
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         srem_in = SREM_W'(rem_cat);
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
      len_in = (root_ff == '0) ? ROOT_W'(1) : root_ff;

      // one quotient bit a cycle in each lane
      for (int k = 0; k < 3; k++) begin
         num[k]    = (NUM_W'(mag_ff[k]) << FRAC_BITS) + NUM_W'(len_in >> 1);
         dshift[k] = {drem_ff[k], dnum_ff[k][DIV_STEPS-1]};
         qbit[k]   = (dshift[k] >= {1'b0, len_ff});
         drem_in[k] = qbit[k] ? ROOT_W'(dshift[k] - {1'b0, len_ff}) : ROOT_W'(dshift[k]);
         qclip[k]  = (quo_ff[k] > DIV_STEPS'(NORM_ONE)) ? DIV_STEPS'(NORM_ONE) : quo_ff[k];
         if (degen_ff) begin
            norm[k] = '0;
         end else if (neg_ff[k]) begin
            norm[k] = -NORM_W'(qclip[k]);
         end else begin
            norm[k] = NORM_W'(qclip[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         facet_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            facet_ff     <= facet_ff + FACET_W'(1);
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            addr_b_ff <= job.addr_1;
            addr_c_ff <= job.addr_2;
         end
         BK_READ_B: va_ff <= rd_c;
         BK_READ_C: vb_ff <= rd_c;
         BK_TAKE_C: begin
            for (int k = 0; k < 3; k++) begin
               u_ff[k] <= DIFF_W'(vb_ff[k]) - DIFF_W'(va_ff[k]);
               v_ff[k] <= DIFF_W'(rd_c[k]) - DIFF_W'(va_ff[k]);
            end
         end
         BK_MULT: begin
            p_ff[0] <= u_ff[1] * v_ff[2];
            p_ff[1] <= u_ff[2] * v_ff[1];
            p_ff[2] <= u_ff[2] * v_ff[0];
            p_ff[3] <= u_ff[0] * v_ff[2];
            p_ff[4] <= u_ff[0] * v_ff[1];
            p_ff[5] <= u_ff[1] * v_ff[0];
         end
         BK_CROSS: begin
            c_ff     <= c_in;
            degen_ff <= degen_in;
         end
         BK_SCALE: begin
            for (int k = 0; k < 3; k++) begin
               mag_ff[k] <= MAG_W'(abs_c[k] >> shift_amt);
               neg_ff[k] <= c_ff[k][CROSS_W-1];
            end
         end
         BK_SQUARE: begin
            for (int k = 0; k < 3; k++) begin
               sq_ff[k] <= SQ_W'(mag_ff[k]) * SQ_W'(mag_ff[k]);
            end
         end
         BK_SUM: begin
            sum_ff  <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
            root_ff <= '0;
            srem_ff <= '0;
            iter_ff <= ITER_W'(ROOT_STEPS - 1);
         end
         BK_ROOT: begin
            root_ff <= root_in;
            srem_ff <= srem_in;
            sum_ff  <= sum_ff << 2;
            iter_ff <= iter_ff - ITER_W'(1);
         end
         BK_PREP: begin
            len_ff <= len_in;
            for (int k = 0; k < 3; k++) begin
               drem_ff[k] <= ROOT_W'(num[k] >> DIV_STEPS);
               dnum_ff[k] <= num[k][DIV_STEPS-1:0];
               quo_ff[k]  <= '0;
            end
            iter_ff <= ITER_W'(DIV_STEPS - 1);
         end
         BK_DIVIDE: begin
            for (int k = 0; k < 3; k++) begin
               drem_ff[k] <= drem_in[k];
               dnum_ff[k] <= dnum_ff[k] << 1;
               quo_ff[k]  <= {quo_ff[k][DIV_STEPS-2:0], qbit[k]};
            end
            iter_ff <= iter_ff - ITER_W'(1);
         end
         BK_DONE: begin
            if (rsp_load) begin
               rsp_ff.normal_x     <= norm[0];
               rsp_ff.normal_y     <= norm[1];
               rsp_ff.normal_z     <= norm[2];
               rsp_ff.degenerate   <= degen_ff;
               rsp_ff.facet_number <= facet_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> test/triangle_facet_normal_checker.sv
// checker that predicts and compares the facet normals of the triangle facet normal block
`timescale 1ns / 1ps

module triangle_facet_normal_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  tfn_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  tfn_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               pending
);
   import tfn_pkg::*;

   vertex_type      vertex_mirror [1024];
   logic [19:0]     facet_count;
   rsp_type         normals_due [$];

   initial begin
      fail_count = 0;
      for (int i = 0; i < 1024; i++) vertex_mirror[i] = '0;
   end

   assign pending = normals_due.size();

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic rsp_type facet_normal(input vertex_type va, input vertex_type vb,
                                            input vertex_type vc, input logic [19:0] num);
      longint u [3];
      longint v [3];
      longint cr [3];
      longint unsigned mag [3];
      longint unsigned maxm, sum, len, q, rem, res, bitv;
      int s;
      rsp_type r;
      r = '0;
      u[0] = longint'(vb.x) - longint'(va.x);
      u[1] = longint'(vb.y) - longint'(va.y);
      u[2] = longint'(vb.z) - longint'(va.z);
      v[0] = longint'(vc.x) - longint'(va.x);
      v[1] = longint'(vc.y) - longint'(va.y);
      v[2] = longint'(vc.z) - longint'(va.z);
      cr[0] = u[1] * v[2] - u[2] * v[1];
      cr[1] = u[2] * v[0] - u[0] * v[2];
      cr[2] = u[0] * v[1] - u[1] * v[0];
      r.facet_number = num;
      if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      maxm = 0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = (cr[k] < 0) ? longint'(-cr[k]) : longint'(cr[k]);
         if (mag[k] > maxm) maxm = mag[k];
      end
      // bring the largest magnitude below 2^30
      s = 0;
      while ((maxm >> s) >= (64'd1 << 30)) s++;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = mag[k] >> s;
         sum += mag[k] * mag[k];
      end
      // digit-by-digit integer square root
      rem = sum;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      len = (res == 0) ? 1 : res;
      for (int k = 0; k < 3; k++) begin
         q = (mag[k] * NORM_ONE + (len >> 1)) / len;
         if (q > NORM_ONE) q = NORM_ONE;
         if (cr[k] < 0) q = -q;
         case (k)
            0: r.normal_x = q[15:0];
            1: r.normal_y = q[15:0];
            default: r.normal_z = q[15:0];
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         facet_count <= '0;
         normals_due.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_payload.command == CMD_LOAD) begin
               vertex_mirror[req_payload.vertex_slot] <= '{req_payload.coord_x,
                  req_payload.coord_y, req_payload.coord_z};
            end else begin
               normals_due.insert(normals_due.size(),
                  facet_normal(vertex_mirror[req_payload.corner_a],
                  vertex_mirror[req_payload.corner_b], vertex_mirror[req_payload.corner_c],
                  facet_count));
               facet_count <= facet_count + 20'd1;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (normals_due.size() == 0) begin
               report_mismatch("unexpected item facet_number", rsp_payload.facet_number, -1);
            end else begin
               want = normals_due.pop_front();
               if (rsp_payload.normal_x !== want.normal_x)
                  report_mismatch("normal_x", rsp_payload.normal_x, want.normal_x);
               if (rsp_payload.normal_y !== want.normal_y)
                  report_mismatch("normal_y", rsp_payload.normal_y, want.normal_y);
               if (rsp_payload.normal_z !== want.normal_z)
                  report_mismatch("normal_z", rsp_payload.normal_z, want.normal_z);
               if (rsp_payload.degenerate !== want.degenerate)
                  report_mismatch("degenerate", rsp_payload.degenerate, want.degenerate);
               if (rsp_payload.facet_number !== want.facet_number)
                  report_mismatch("facet_number", rsp_payload.facet_number,
                                  want.facet_number);
            end
         end
      end
   end

endmodule

>>> test/tb_triangle_facet_normal_top.sv
// testbench top of the triangle facet normal block: stimulus and verdict
`timescale 1ns / 1ps

module tb_triangle_facet_normal_top;
   import tfn_pkg::*;

   localparam int STALL_LIMIT = 20000;   // cycles with no item moving
   localparam int DRAIN_WAIT  = 120;     // further wait in drain after the last expected item is in

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int fail_count;
   int pending;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_ticket;
   int items_sent;
   int loaded_slots [$];
   bit slot_loaded [1024];

   triangle_facet_normal_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   triangle_facet_normal_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off each time the ticket moves
   initial begin
      int seen_ticket;
      int hold_left;
      seen_ticket = 0;
      hold_left   = 0;
      rsp_ready   = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ticket != seen_ticket) begin
            seen_ticket = hold_ticket;
            hold_left   = 1500;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: cycles in which neither channel moves an item
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("** triangle_facet_normal_top: FAILED **");
            $finish;
         end
      end
   end

   // offer one item; valid stays high into the next item when no gap is drawn
   task automatic send_item(input req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic load_vertex(input int slot, input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
      req_type item;
      item             = req_type'({$urandom, $urandom, $urandom});
      item.command     = CMD_LOAD;
      item.vertex_slot = SLOT_W'(slot);
      item.coord_x     = x;
      item.coord_y     = y;
      item.coord_z     = z;
      send_item(item);
      if (!slot_loaded[slot]) begin
         slot_loaded[slot] = 1'b1;
         loaded_slots.insert(loaded_slots.size(), slot);
      end
   endtask

   task automatic triangle(input int a, input int b, input int c);
      req_type item;
      item          = req_type'({$urandom, $urandom, $urandom});
      item.command  = CMD_TRI;
      item.corner_a = SLOT_W'(a);
      item.corner_b = SLOT_W'(b);
      item.corner_c = SLOT_W'(c);
      send_item(item);
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(3))
         0:       return 16'($signed($urandom_range(0, 64)) - 32);   // near the origin
         1:       return $urandom_range(1) ? 16'h7fff : 16'h8000;    // extremes
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int any_loaded();
      return loaded_slots[$urandom_range(loaded_slots.size() - 1)];
   endfunction

   // mostly load-three-then-triangle sequences, some lone items as noise
   task automatic random_items(input int count);
      int stop_at;
      int a, b, c;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 80) begin
            a = $urandom_range(1023);
            b = $urandom_range(1023);
            c = $urandom_range(1023);
            load_vertex(a, rand_coord(), rand_coord(), rand_coord());
            load_vertex(b, rand_coord(), rand_coord(), rand_coord());
            load_vertex(c, rand_coord(), rand_coord(), rand_coord());
            triangle(a, b, c);
         end else if ($urandom_range(1)) begin
            triangle(any_loaded(), any_loaded(), any_loaded());
         end else begin
            load_vertex($urandom_range(1023), rand_coord(), rand_coord(), rand_coord());
         end
      end
   endtask

   // every expected item in, then a further DRAIN_WAIT wait
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      send_idle_pct = 33;
      recv_idle_pct = 56;
      hold_ticket   = 0;
      items_sent    = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of the coordinates and slots
      load_vertex(0,    16'h8000, 16'h8000, 16'h8000);
      load_vertex(1023, 16'h7fff, 16'h7fff, 16'h7fff);
      load_vertex(512,  16'h7fff, 16'h8000, 16'h0000);
      load_vertex(341,  16'h8000, 16'h7fff, 16'h7fff);
      load_vertex(682,  16'h0000, 16'h0000, 16'h0000);
      triangle(0, 1023, 512);
      triangle(512, 341, 0);
      triangle(1023, 0, 341);
      // unit axes give exact unit normals
      load_vertex(1, 16'h0100, 16'h0000, 16'h0000);
      load_vertex(2, 16'h0000, 16'h0100, 16'h0000);
      load_vertex(3, 16'h0000, 16'h0000, 16'h0100);
      triangle(682, 1, 2);
      triangle(682, 2, 3);
      triangle(682, 3, 1);
      triangle(682, 2, 1);
      // degenerate: repeated corners, a collinear corner, all corners equal
      load_vertex(4, 16'h0200, 16'h0000, 16'h0000);
      triangle(682, 1, 4);
      triangle(1, 1, 2);
      triangle(0, 0, 0);
      // reload a slot and reuse it
      load_vertex(1, 16'hff00, 16'h0001, 16'h7fff);
      triangle(1, 2, 3);
      drain();

      // receiver long hold-off while the sender keeps offering items
      hold_ticket++;
      random_items(150);
      drain();
      random_items(450);
      drain();

      send_idle_pct = 56;
      recv_idle_pct = 33;
      random_items(600);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_items(600);
      drain();

      if (fail_count == 0) begin
         $display("** triangle_facet_normal_top: PASSED **");
      end else begin
         $display("** triangle_facet_normal_top: FAILED **");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/tfn_pkg.sv
rtl/tfn_ram.sv
rtl/tfn_front.sv
rtl/tfn_queue.sv
rtl/tfn_back.sv
rtl/triangle_facet_normal_top.sv
test/triangle_facet_normal_checker.sv
test/tb_triangle_facet_normal_top.sv
